// ===== hw/rtl/lisa_pkg.sv =====
// ----------------------------------------------------------------------------
// lisa_pkg
// Shared widths, register indexes and the divider step for the strided
// address generator.
// ----------------------------------------------------------------------------
package lisa_pkg;

  localparam int MAX_DIMS   = 3;   // dimensions in use, counted from the innermost
  localparam int HW_DIMS    = 3;   // dimensions the register file holds
  localparam int IDX_W      = 48;
  localparam int EXT_W      = 16;
  localparam int STRIDE_W   = 32;
  localparam int ADDR_W     = 64;
  localparam int BASE_W     = 48;
  localparam int PROD_W     = EXT_W + STRIDE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Quotient bits resolved per divider stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = IDX_W / DIV_BITS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_OUTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_MIDDLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_INNER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_OUTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_MIDDLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_INNER  = 3'd6;

  // Partial remainder and shifting dividend/quotient word
  typedef struct packed {
    logic [EXT_W-1:0] rem;
    logic [IDX_W-1:0] quot;
  } div_t;

  // Resolve DIV_BITS quotient bits by restoring division
  function automatic div_t div_step(div_t cur, logic [EXT_W-1:0] d);
    logic [EXT_W:0] t;
    div_t           res;
    res = cur;
    for (int i = 0; i < DIV_BITS; i++) begin
      t        = {res.rem, res.quot[IDX_W-1]};
      res.quot = {res.quot[IDX_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t           = t - {1'b0, d};
        res.quot[0] = 1'b1;
      end
      res.rem = t[EXT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/lisa_div.sv =====
// ----------------------------------------------------------------------------
// lisa_div
// Pipelined 48 by 16 bit divider, DIV_BITS quotient bits per stage. Carries
// the running offset alongside each transaction.
// ----------------------------------------------------------------------------
module lisa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [lisa_pkg::IDX_W-1:0]   in_quot,
  input  logic [lisa_pkg::ADDR_W-1:0]  in_acc,
  input  logic [lisa_pkg::EXT_W-1:0]   divisor,
  output logic                         out_valid,
  output logic [lisa_pkg::IDX_W-1:0]   out_quot,
  output logic [lisa_pkg::EXT_W-1:0]   out_rem,
  output logic [lisa_pkg::ADDR_W-1:0]  out_acc
);
  import lisa_pkg::*;

  logic              vld      [DIV_STAGES];
  div_t              st       [DIV_STAGES];
  logic [ADDR_W-1:0] acc      [DIV_STAGES];
  div_t              st_next  [DIV_STAGES];

  // Each stage works on the word held by the stage before it
  always_comb begin
    st_next[0] = div_step(div_t'{rem: '0, quot: in_quot}, divisor);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_next[s] = div_step(st[s-1], divisor);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) vld[s] <= vld[s-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]  <= st_next[0];
      acc[0] <= in_acc;
      for (int s = 1; s < DIV_STAGES; s++) begin
        st[s]  <= st_next[s];
        acc[s] <= acc[s-1];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quot  = st[DIV_STAGES-1].quot;
  assign out_rem   = st[DIV_STAGES-1].rem;
  assign out_acc   = acc[DIV_STAGES-1];

endmodule

// ===== hw/rtl/lisa_mac.sv =====
// ----------------------------------------------------------------------------
// lisa_mac
// Two-stage multiply-accumulate: digit times stride, then add to the offset.
// ----------------------------------------------------------------------------
module lisa_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [lisa_pkg::IDX_W-1:0]     in_quot,
  input  logic [lisa_pkg::EXT_W-1:0]     in_digit,
  input  logic [lisa_pkg::ADDR_W-1:0]    in_acc,
  input  logic [lisa_pkg::STRIDE_W-1:0]  stride,
  output logic                           out_valid,
  output logic [lisa_pkg::IDX_W-1:0]     out_quot,
  output logic [lisa_pkg::ADDR_W-1:0]    out_acc
);
  import lisa_pkg::*;

  logic              mul_vld;
  logic [IDX_W-1:0]  mul_quot;
  logic [ADDR_W-1:0] mul_acc;
  logic [PROD_W-1:0] mul_prod;
  logic              add_vld;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      add_vld <= 1'b0;
    end else if (en) begin
      mul_vld <= in_valid;
      add_vld <= mul_vld;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (en) begin
      mul_prod <= PROD_W'(in_digit) * PROD_W'(stride);
      mul_quot <= in_quot;
      mul_acc  <= in_acc;
      out_quot <= mul_quot;
      out_acc  <= mul_acc + ADDR_W'(mul_prod);
    end
  end

  assign out_valid = add_vld;

endmodule

// ===== hw/rtl/linear_index_to_strided_address_core.sv =====
// ----------------------------------------------------------------------------
// linear_index_to_strided_address_core
// Unravels a C-order linear index into a strided array of up to three
// dimensions and returns base address plus strided byte offset.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the output stalls; each
//   dimension has its own 12-stage divider and multiply-add, so the
//   pipeline never waits on a shared unit.
// A stall on the output freezes the whole pipeline in place.
// Reset clears the valid bits and loads the register defaults (extents 1,
//   inner stride 8, other strides and base 0).
module linear_index_to_strided_address_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,   // [47:0] linear_index
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [63:0]                        m_tdata,   // [63:0] byte_address
  input  logic                               cfg_wr_en,
  input  logic [lisa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lisa_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
  import lisa_pkg::*;

  logic [BASE_W-1:0]   base;
  logic [EXT_W-1:0]    extent [HW_DIMS];   // 0 is the innermost dimension
  logic [STRIDE_W-1:0] stride [HW_DIMS];
  logic                en;

  logic                chain_vld  [MAX_DIMS+1];
  logic [IDX_W-1:0]    chain_quot [MAX_DIMS+1];
  logic [ADDR_W-1:0]   chain_acc  [MAX_DIMS+1];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      extent[0] <= EXT_W'(1);
      extent[1] <= EXT_W'(1);
      extent[2] <= EXT_W'(1);
      stride[0] <= STRIDE_W'(8);
      stride[1] <= '0;
      stride[2] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BASE:          base      <= cfg_wr_data[BASE_W-1:0];
        REG_EXTENT_OUTER:  extent[2] <= cfg_wr_data[EXT_W-1:0];
        REG_EXTENT_MIDDLE: extent[1] <= cfg_wr_data[EXT_W-1:0];
        REG_EXTENT_INNER:  extent[0] <= cfg_wr_data[EXT_W-1:0];
        REG_STRIDE_OUTER:  stride[2] <= cfg_wr_data[STRIDE_W-1:0];
        REG_STRIDE_MIDDLE: stride[1] <= cfg_wr_data[STRIDE_W-1:0];
        REG_STRIDE_INNER:  stride[0] <= cfg_wr_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign chain_vld[0]  = s_tvalid;
  assign chain_quot[0] = s_tdata[IDX_W-1:0];
  assign chain_acc[0]  = '0;

  // One divider and multiply-add per dimension, innermost first
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    logic             div_vld;
    logic [IDX_W-1:0] div_quot;
    logic [EXT_W-1:0] div_rem;
    logic [ADDR_W-1:0] div_acc;
    logic [EXT_W-1:0] divisor;

    // Treat a zero extent as one
    assign divisor = (extent[d] == '0) ? EXT_W'(1) : extent[d];

    lisa_div u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_vld[d]),
      .in_quot   (chain_quot[d]),
      .in_acc    (chain_acc[d]),
      .divisor   (divisor),
      .out_valid (div_vld),
      .out_quot  (div_quot),
      .out_rem   (div_rem),
      .out_acc   (div_acc)
    );

    lisa_mac u_mac (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_vld),
      .in_quot   (div_quot),
      .in_digit  (div_rem),
      .in_acc    (div_acc),
      .stride    (stride[d]),
      .out_valid (chain_vld[d+1]),
      .out_quot  (chain_quot[d+1]),
      .out_acc   (chain_acc[d+1])
    );
  end

  // Output register: add the base address
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain_vld[MAX_DIMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= chain_acc[MAX_DIMS] + ADDR_W'(base);
    end
  end

endmodule
